>>> rtl/sorted_key_binary_search_assert.svh
// Assertion macros for the sorted key search block.
// Expects clk_i and rst_ni in the scope of every use.
`ifndef SORTED_KEY_BINARY_SEARCH_ASSERT_SVH
`define SORTED_KEY_BINARY_SEARCH_ASSERT_SVH

// A property that must hold at every clock edge outside of reset.
`define SKBS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// A condition that must never be true outside of reset.
`define SKBS_ASSERT_NEVER(label, cond, msg) \
  `SKBS_ASSERT(label, !(cond), msg)

`endif

>>> rtl/skbs_pkg.sv
// Package for the sorted key search block: field widths and operation codes.
// No dependencies; used by the interfaces and by the top level.
`default_nettype none

package skbs_pkg;

  localparam int FUNC_W     = 1;
  localparam int POS_W      = 10;
  localparam int KEY_W      = 64;
  localparam int CNT_W      = 11;
  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 3;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_LOAD   = 1'b0,
    FUNC_SEARCH = 1'b1
  } func_e;

  // Register index, taken from the word address bits of paddr.
  typedef enum logic [APB_ADDR_W-3:0] {
    REG_KEY_COUNT = 1'b0
  } reg_idx_e;

  localparam logic [CNT_W-1:0] KEY_COUNT_RST = 11'd1;

endpackage

`default_nettype wire

>>> rtl/skbs_req_if.sv
// Request channel of the sorted key search block: load or search items.
// Depends on skbs_pkg for widths and the operation code type.
`default_nettype none

interface skbs_req_if;
  logic                          valid;
  logic                          ready;
  skbs_pkg::func_e               func;
  logic [skbs_pkg::POS_W-1:0]    position;
  logic [skbs_pkg::KEY_W-1:0]    key;

  modport source (output valid, func, position, key, input ready);
  modport sink (input valid, func, position, key, output ready);
endinterface

`default_nettype wire

>>> rtl/skbs_rsp_if.sv
// Response channel of the sorted key search block: one item per search.
// Depends on skbs_pkg for the result width.
`default_nettype none

interface skbs_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [skbs_pkg::CNT_W-1:0]    result_position;
  logic                          found;

  modport source (output valid, result_position, found, input ready);
  modport sink (input valid, result_position, found, output ready);
endinterface

`default_nettype wire

>>> rtl/skbs_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none

module skbs_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

>>> rtl/sorted_key_binary_search.sv
// Channel   Dir   Payload                          Accepted when
// req_i     in    func, position, key              req_i.valid && req_i.ready
// rsp_o     out   result_position, found           rsp_o.valid && rsp_o.ready
// apb       in    key_count at byte address 0      psel && penable && pwrite
//
// A load item writes the key memory in the cycle it is accepted and gives no item back.
// A search reads the single key memory port once per cycle: start entry, last entry, then
// up to floor(log2(count - start)) + 1 probes, and it holds the block while it runs.
// A start position at or beyond the count is answered without a memory read.
// The result register lets the next item in while a result waits; a search that finishes
// while the register is still full waits in the response state. Reset sets key_count to 1;
// the key memory is not cleared.
// Depends on skbs_pkg, skbs_req_if, skbs_rsp_if, skbs_ram and the assertion header.
`default_nettype none

`include "sorted_key_binary_search_assert.svh"

module sorted_key_binary_search #(
  parameter int TABLE_DEPTH = 1024
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  skbs_req_if.sink                                 req_i,
  skbs_rsp_if.source                               rsp_o,
  input  wire logic                                psel,
  input  wire logic                                penable,
  input  wire logic                                pwrite,
  input  wire logic [skbs_pkg::APB_ADDR_W-1:0]     paddr,
  input  wire logic [skbs_pkg::APB_DATA_W-1:0]     pwdata,
  output logic      [skbs_pkg::APB_DATA_W-1:0]     prdata,
  output logic                                     pready
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = skbs_pkg::CNT_W;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_START = 5'b00010,
    ST_LAST  = 5'b00100,
    ST_PROBE = 5'b01000,
    ST_RESP  = 5'b10000
  } state_e;

  state_e                     state_q, state_d;
  logic [skbs_pkg::KEY_W-1:0] key_q, key_d;
  logic [CW-1:0]              lo_q, lo_d;
  logic [CW-1:0]              end_q, end_d;
  logic [CW-1:0]              mid_q, mid_d;
  logic [CW-1:0]              n_q, n_d;
  logic [CW-1:0]              res_pos_q, res_pos_d;
  logic                       res_found_q, res_found_d;
  logic                       out_valid_q, out_valid_d;
  logic [CW-1:0]              out_pos_q, out_pos_d;
  logic                       out_found_q, out_found_d;
  logic [CW-1:0]              key_count_q, key_count_d;

  logic                       ram_we, ram_re;
  logic [AW-1:0]              ram_waddr, ram_raddr;
  logic [skbs_pkg::KEY_W-1:0] ram_wdata, ram_rdata;

  logic [CW-1:0]              n_eff;
  logic [CW-1:0]              start_pos;
  logic                       key_eq, key_lt;
  logic [CW-1:0]              lo_nx, end_nx;
  logic                       cfg_wr;
  skbs_pkg::reg_idx_e         cfg_idx;

  // Midpoint of the half-open range [lo, end), equal to lo + (hi - lo) / 2 with hi = end - 1.
  function automatic logic [CW-1:0] mid_of(input logic [CW-1:0] lo, input logic [CW-1:0] en);
    logic [CW-1:0] span;
    span = en - lo - CW'(1);
    return lo + (span >> 1);
  endfunction

  skbs_ram #(
    .WIDTH (skbs_pkg::KEY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_key_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Configuration port.
  assign pready  = 1'b1;
  assign cfg_idx = skbs_pkg::reg_idx_e'(paddr[skbs_pkg::APB_ADDR_W-1:2]);
  assign cfg_wr  = psel && penable && pwrite && (cfg_idx == skbs_pkg::REG_KEY_COUNT);

  always_comb begin
    key_count_d = key_count_q;
    if (cfg_wr) begin
      key_count_d = pwdata[CW-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (cfg_idx == skbs_pkg::REG_KEY_COUNT) begin
      prdata = skbs_pkg::APB_DATA_W'(key_count_q);
    end
  end

  // A count above the table depth saturates to the depth.
  assign n_eff = (32'(key_count_q) > TABLE_DEPTH) ? CW'(TABLE_DEPTH) : key_count_q;
  assign start_pos = CW'(req_i.position);

  assign key_eq = (ram_rdata == key_q);
  assign key_lt = (key_q < ram_rdata);
  assign lo_nx  = key_lt ? lo_q : mid_q + CW'(1);
  assign end_nx = key_lt ? mid_q : end_q;

  assign req_i.ready          = (state_q == ST_IDLE);
  assign rsp_o.valid          = out_valid_q;
  assign rsp_o.result_position = out_pos_q;
  assign rsp_o.found          = out_found_q;

  always_comb begin
    state_d     = state_q;
    key_d       = key_q;
    lo_d        = lo_q;
    end_d       = end_q;
    mid_d       = mid_q;
    n_d         = n_q;
    res_pos_d   = res_pos_q;
    res_found_d = res_found_q;
    out_valid_d = out_valid_q && !rsp_o.ready;
    out_pos_d   = out_pos_q;
    out_found_d = out_found_q;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    ram_waddr   = AW'(req_i.position);
    ram_wdata   = req_i.key;
    ram_raddr   = '0;

    case (state_q)
      ST_IDLE: begin
        if (req_i.valid) begin
          if (req_i.func == skbs_pkg::FUNC_LOAD) begin
            // Loads beyond the table are dropped.
            ram_we = (32'(req_i.position) < TABLE_DEPTH);
          end else begin
            key_d = req_i.key;
            n_d   = n_eff;
            lo_d  = start_pos;
            end_d = n_eff;
            if (start_pos >= n_eff) begin
              res_pos_d   = n_eff;
              res_found_d = 1'b0;
              state_d     = ST_RESP;
            end else begin
              ram_re    = 1'b1;
              ram_raddr = AW'(req_i.position);
              state_d   = ST_START;
            end
          end
        end
      end
      ST_START: begin
        if (key_eq) begin
          res_pos_d   = lo_q;
          res_found_d = 1'b1;
          state_d     = ST_RESP;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = AW'(end_q - CW'(1));
          state_d   = ST_LAST;
        end
      end
      ST_LAST: begin
        if (key_eq) begin
          res_pos_d   = end_q - CW'(1);
          res_found_d = 1'b1;
          state_d     = ST_RESP;
        end else begin
          mid_d     = mid_of(lo_q, end_q);
          ram_re    = 1'b1;
          ram_raddr = AW'(mid_of(lo_q, end_q));
          state_d   = ST_PROBE;
        end
      end
      ST_PROBE: begin
        if (key_eq) begin
          res_pos_d   = mid_q;
          res_found_d = 1'b1;
          state_d     = ST_RESP;
        end else begin
          lo_d  = lo_nx;
          end_d = end_nx;
          if (lo_nx < end_nx) begin
            mid_d     = mid_of(lo_nx, end_nx);
            ram_re    = 1'b1;
            ram_raddr = AW'(mid_of(lo_nx, end_nx));
          end else begin
            res_pos_d   = lo_nx;
            res_found_d = 1'b0;
            state_d     = ST_RESP;
          end
        end
      end
      ST_RESP: begin
        if (!out_valid_q || rsp_o.ready) begin
          out_valid_d = 1'b1;
          out_pos_d   = res_pos_q;
          out_found_d = res_found_q;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      key_count_q <= skbs_pkg::KEY_COUNT_RST;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      key_count_q <= key_count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q       <= key_d;
    lo_q        <= lo_d;
    end_q       <= end_d;
    mid_q       <= mid_d;
    n_q         <= n_d;
    res_pos_q   <= res_pos_d;
    res_found_q <= res_found_d;
    out_pos_q   <= out_pos_d;
    out_found_q <= out_found_d;
  end

  // Only entries below the count latched for the search are ever read.
  `SKBS_ASSERT(a_read_below_count, (ram_re && state_q != ST_IDLE) |-> (ram_raddr < n_q), "key read at or beyond count")
  // The probe loop only runs on a non-empty range.
  `SKBS_ASSERT(a_probe_range, (state_q == ST_PROBE) |-> (lo_q < end_q), "probe on empty range")
  // An accepted search always leaves the idle state.
  `SKBS_ASSERT(a_search_busy, (req_i.valid && req_i.ready && req_i.func == skbs_pkg::FUNC_SEARCH) |=> (state_q != ST_IDLE), "search did not start")
  // Loads and search reads never share a cycle on the memory.
  `SKBS_ASSERT_NEVER(a_rw_excl, ram_we && ram_re, "memory write and read in one cycle")
  // A result is only loaded into a free or draining output register.
  `SKBS_ASSERT(a_no_overwrite, (state_q == ST_RESP && out_valid_q && !rsp_o.ready) |=> (state_q == ST_RESP), "result register overwritten")

endmodule

`default_nettype wire

>>> sim/sorted_key_binary_search_tb.sv
// Testbench for sorted_key_binary_search: a directed table, then random load and search phases,
// with results checked against typed values or a shadow copy of the key table and key_count.
// Depends on skbs_pkg, skbs_req_if, skbs_rsp_if and the sorted_key_binary_search RTL.
`default_nettype none

module sorted_key_binary_search_tb;

  localparam int TABLE_DEPTH  = 1024;
  localparam int TOTAL_ITEMS  = 1375;
  localparam int DRAIN_CYCLES = 20;
  localparam int KEY_W        = skbs_pkg::KEY_W;
  localparam int CNT_W        = skbs_pkg::CNT_W;
  localparam int POS_W        = skbs_pkg::POS_W;
  localparam int APB_ADDR_W   = skbs_pkg::APB_ADDR_W;
  localparam int APB_DATA_W   = skbs_pkg::APB_DATA_W;
  localparam skbs_pkg::func_e FUNC_LOAD   = skbs_pkg::FUNC_LOAD;
  localparam skbs_pkg::func_e FUNC_SEARCH = skbs_pkg::FUNC_SEARCH;
  localparam logic [KEY_W-1:0] KEY_MAX = '1;

  typedef struct packed {
    logic [CNT_W-1:0] pos;
    logic             found;
  } search_result_t;

  typedef enum bit {ROW_ITEM, ROW_REG} row_kind_e;

  // For a register row the key column holds the key_count value.
  typedef struct packed {
    row_kind_e          kind;
    skbs_pkg::func_e    func;
    logic [POS_W-1:0]   pos;
    logic [KEY_W-1:0]   key;
    bit                 typed;
    search_result_t     res;
  } dir_row_t;

  localparam dir_row_t DIRECTED [25] = '{
    '{ROW_ITEM, FUNC_LOAD,   10'd0,    64'h0,                 1'b0, '{11'd0, 1'b0}},
    '{ROW_ITEM, FUNC_SEARCH, 10'd0,    64'h0,                 1'b1, '{11'd0, 1'b1}},
    '{ROW_ITEM, FUNC_SEARCH, 10'd0,    KEY_MAX,               1'b1, '{11'd1, 1'b0}},
    '{ROW_ITEM, FUNC_SEARCH, 10'd1,    64'h5,                 1'b1, '{11'd1, 1'b0}},
    '{ROW_ITEM, FUNC_SEARCH, 10'd1023, 64'h0,                 1'b1, '{11'd1, 1'b0}},
    '{ROW_ITEM, FUNC_LOAD,   10'd0,    KEY_MAX,               1'b0, '{11'd0, 1'b0}},
    '{ROW_ITEM, FUNC_SEARCH, 10'd0,    64'h0,                 1'b1, '{11'd0, 1'b0}},
    '{ROW_ITEM, FUNC_SEARCH, 10'd0,    KEY_MAX,               1'b1, '{11'd0, 1'b1}},
    '{ROW_ITEM, FUNC_LOAD,   10'd1023, 64'h5555_5555_5555_5555, 1'b0, '{11'd0, 1'b0}},
    '{ROW_ITEM, FUNC_LOAD,   10'd0,    64'h00,                1'b0, '{11'd0, 1'b0}},
    '{ROW_ITEM, FUNC_LOAD,   10'd1,    64'h10,                1'b0, '{11'd0, 1'b0}},
    '{ROW_ITEM, FUNC_LOAD,   10'd2,    64'h20,                1'b0, '{11'd0, 1'b0}},
    '{ROW_ITEM, FUNC_LOAD,   10'd3,    64'h30,                1'b0, '{11'd0, 1'b0}},
    '{ROW_ITEM, FUNC_LOAD,   10'd4,    64'h40,                1'b0, '{11'd0, 1'b0}},
    '{ROW_ITEM, FUNC_LOAD,   10'd5,    64'h50,                1'b0, '{11'd0, 1'b0}},
    '{ROW_ITEM, FUNC_LOAD,   10'd6,    64'h60,                1'b0, '{11'd0, 1'b0}},
    '{ROW_ITEM, FUNC_LOAD,   10'd7,    64'h70,                1'b0, '{11'd0, 1'b0}},
    '{ROW_REG,  FUNC_LOAD,   10'd0,    64'd8,                 1'b0, '{11'd0, 1'b0}},
    '{ROW_ITEM, FUNC_SEARCH, 10'd0,    64'h30,                1'b0, '{11'd0, 1'b0}},
    '{ROW_ITEM, FUNC_SEARCH, 10'd3,    64'h35,                1'b0, '{11'd0, 1'b0}},
    '{ROW_ITEM, FUNC_SEARCH, 10'd0,    64'h70,                1'b1, '{11'd7, 1'b1}},
    '{ROW_ITEM, FUNC_SEARCH, 10'd8,    64'h30,                1'b1, '{11'd8, 1'b0}},
    '{ROW_ITEM, FUNC_SEARCH, 10'd2,    64'h0,                 1'b0, '{11'd0, 1'b0}},
    '{ROW_REG,  FUNC_LOAD,   10'd0,    64'd0,                 1'b0, '{11'd0, 1'b0}},
    '{ROW_ITEM, FUNC_SEARCH, 10'd0,    64'h0,                 1'b1, '{11'd0, 1'b0}}
  };

  logic                  clk_i;
  logic                  rst_ni;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  skbs_req_if req_bus ();
  skbs_rsp_if rsp_bus ();

  logic [KEY_W-1:0] shadow_keys [TABLE_DEPTH];
  logic [CNT_W-1:0] shadow_count;
  search_result_t   pending_results [$];
  int               mismatches;
  int               items_sent;
  bit               no_idle;

  sorted_key_binary_search #(.TABLE_DEPTH(TABLE_DEPTH)) DUT (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (req_bus),
    .rsp_o   (rsp_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #1_000_000;
    $display("sorted_key_binary_search_tb NOT OK");
    $finish;
  end

  // Start entry, then last entry, then a binary search from start to the last entry.
  function automatic search_result_t predict_search(input logic [KEY_W-1:0] k,
                                                    input logic [POS_W-1:0] start);
    int n;
    int lo;
    int hi;
    int mid;
    search_result_t r;
    n = (shadow_count > TABLE_DEPTH) ? TABLE_DEPTH : int'(shadow_count);
    if (int'(start) >= n) begin
      r = '{CNT_W'(n), 1'b0};
      return r;
    end
    if (shadow_keys[start] == k) return search_result_t'{CNT_W'(start), 1'b1};
    if (shadow_keys[n-1] == k) return search_result_t'{CNT_W'(n - 1), 1'b1};
    lo = int'(start);
    hi = n - 1;
    while (lo <= hi) begin
      mid = lo + (hi - lo) / 2;
      if (shadow_keys[mid] == k) return search_result_t'{CNT_W'(mid), 1'b1};
      if (k < shadow_keys[mid]) hi = mid - 1;
      else lo = mid + 1;
    end
    return search_result_t'{CNT_W'(lo), 1'b0};
  endfunction

  task automatic note_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("%s", msg);
  endtask

  // Called at a falling edge; returns at the falling edge after the item is accepted.
  task automatic push_req(input skbs_pkg::func_e f, input logic [POS_W-1:0] p,
                          input logic [KEY_W-1:0] k,
                          input bit typed, input search_result_t typed_res);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 9);
    if (gap != 0) begin
      req_bus.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    req_bus.valid    <= 1'b1;
    req_bus.func     <= f;
    req_bus.position <= p;
    req_bus.key      <= k;
    @(posedge clk_i);
    while (!req_bus.ready) @(posedge clk_i);
    items_sent++;
    if (f == FUNC_LOAD) shadow_keys[p] = k;
    else pending_results = {pending_results, (typed ? typed_res : predict_search(k, p))};
    @(negedge clk_i);
  endtask

  task automatic drain_results();
    req_bus.valid <= 1'b0;
    do @(negedge clk_i); while (pending_results.size() != 0);
  endtask

  task automatic set_key_count(input int value);
    drain_results();
    // A load gives no result, so let the block settle before touching the register.
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= {skbs_pkg::REG_KEY_COUNT, 2'b00};
    pwdata  <= APB_DATA_W'(value);
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    shadow_count = CNT_W'(value);
    @(negedge clk_i);
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if (prdata !== APB_DATA_W'(shadow_count))
      note_mismatch($sformatf("key_count readback: expected %0d, got %0d",
                              shadow_count, prdata));
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Fills slots 0..n-1 with ascending keys; a zero step now and then gives duplicates.
  task automatic load_sorted_prefix(input int n);
    logic [KEY_W-1:0] v;
    logic [KEY_W-1:0] step;
    int shift;
    shift = $urandom_range(11, 60);
    v = {$urandom, $urandom} >> 1;
    for (int i = 0; i < n; i++) begin
      if (i != 0) begin
        step = ($urandom_range(0, 7) == 0) ? '0 : ({$urandom, $urandom} >> shift);
        v = v + step;
      end
      push_req(FUNC_LOAD, POS_W'(i), v, 1'b0, '0);
    end
  endtask

  initial begin
    int gap;
    search_result_t want;
    rsp_bus.ready = 1'b0;
    @(negedge clk_i);
    forever begin
      gap = no_idle ? 0 : $urandom_range(0, 9);
      if (gap != 0) begin
        rsp_bus.ready <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      rsp_bus.ready <= 1'b1;
      @(posedge clk_i);
      while (!rsp_bus.valid) @(posedge clk_i);
      if (pending_results.size() == 0) begin
        note_mismatch($sformatf("unexpected result: position %0d found %0b",
                                rsp_bus.result_position, rsp_bus.found));
      end else begin
        want = pending_results.pop_front();
        if (rsp_bus.result_position !== want.pos || rsp_bus.found !== want.found)
          note_mismatch($sformatf("search result: expected position %0d found %0b, got %0d %0b",
                                  want.pos, want.found, rsp_bus.result_position,
                                  rsp_bus.found));
      end
      @(negedge clk_i);
    end
  end

  initial begin
    int phase;
    int cnt;
    int neff;
    int nsearch;
    int r;
    int idx;
    bit full_done;
    logic [KEY_W-1:0] k;
    logic [POS_W-1:0] start;

    rst_ni           = 1'b0;
    psel             = 1'b0;
    penable          = 1'b0;
    pwrite           = 1'b0;
    paddr            = '0;
    pwdata           = '0;
    req_bus.valid    = 1'b0;
    req_bus.func     = FUNC_LOAD;
    req_bus.position = '0;
    req_bus.key      = '0;
    mismatches       = 0;
    items_sent       = 0;
    no_idle          = 1'b0;
    full_done        = 1'b0;
    shadow_count     = skbs_pkg::KEY_COUNT_RST;
    foreach (shadow_keys[i]) shadow_keys[i] = '0;

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    for (int i = 0; i < $size(DIRECTED); i++) begin
      if (DIRECTED[i].kind == ROW_REG) set_key_count(int'(DIRECTED[i].key));
      else push_req(DIRECTED[i].func, DIRECTED[i].pos, DIRECTED[i].key,
                    DIRECTED[i].typed, DIRECTED[i].res);
    end

    phase = 0;
    while (items_sent < TOTAL_ITEMS) begin
      no_idle = ($urandom_range(0, 4) == 0);
      r = $urandom_range(0, 9);
      if (phase == 3) begin
        cnt = TABLE_DEPTH;
      end else if (full_done && r == 0) begin
        case ($urandom_range(0, 2))
          0:       cnt = TABLE_DEPTH;
          1:       cnt = 2047;
          default: cnt = $urandom_range(TABLE_DEPTH + 1, 2046);
        endcase
      end else if (r == 1) begin
        cnt = 0;
      end else if (r == 2) begin
        cnt = 1;
      end else begin
        cnt = $urandom_range(2, 48);
      end
      neff = (cnt > TABLE_DEPTH) ? TABLE_DEPTH : cnt;

      // Large counts reuse the full table written once; its prefix may since be out of order.
      if (phase == 3) begin
        load_sorted_prefix(TABLE_DEPTH);
        full_done = 1'b1;
      end else if (neff <= 64) begin
        load_sorted_prefix(neff);
        if (neff > 2 && $urandom_range(0, 5) == 0)
          push_req(FUNC_LOAD, POS_W'($urandom_range(0, neff - 1)), {$urandom, $urandom},
                   1'b0, '0);
      end
      set_key_count(cnt);

      nsearch = (neff >= TABLE_DEPTH) ? 40 : $urandom_range(8, 30);
      repeat (nsearch) begin
        idx = (neff == 0) ? 0 : $urandom_range(0, neff - 1);
        case ($urandom_range(0, 9))
          0, 1, 2, 3: k = shadow_keys[idx];
          4:          k = shadow_keys[idx] + 1;
          5:          k = shadow_keys[idx] - 1;
          6:          k = {$urandom, $urandom};
          7:          k = '0;
          8:          k = KEY_MAX;
          default:    k = shadow_keys[(neff == 0) ? 0 : neff - 1];
        endcase
        case ($urandom_range(0, 9))
          0, 1, 2, 3: start = '0;
          4, 5, 6:    start = POS_W'(idx);
          7:          start = POS_W'($urandom_range(0, TABLE_DEPTH - 1));
          8:          start = POS_W'((neff > TABLE_DEPTH - 1) ? TABLE_DEPTH - 1 : neff);
          default:    start = POS_W'($urandom_range(0, idx));
        endcase

        // Loads between searches: outside the valid range, or copying a neighbor,
        // which keeps a sorted table sorted.
        if ($urandom_range(0, 9) == 0) begin
          if (neff < TABLE_DEPTH)
            push_req(FUNC_LOAD, POS_W'($urandom_range(neff, TABLE_DEPTH - 1)),
                     {$urandom, $urandom}, 1'b0, '0);
          else if (idx > 0)
            push_req(FUNC_LOAD, POS_W'(idx), shadow_keys[idx - 1], 1'b0, '0);
        end
        if ($urandom_range(0, 39) == 0) drain_results();
        push_req(FUNC_SEARCH, start, k, 1'b0, '0);
      end
      phase++;
    end

    drain_results();
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (mismatches == 0) begin
      $display("sorted_key_binary_search_tb OK");
    end else begin
      $display("sorted_key_binary_search_tb NOT OK");
    end
    $finish;
  end

endmodule

`default_nettype wire

>>> files.f
+incdir+rtl
rtl/skbs_pkg.sv
rtl/skbs_req_if.sv
rtl/skbs_rsp_if.sv
rtl/skbs_ram.sv
rtl/sorted_key_binary_search.sv
sim/sorted_key_binary_search_tb.sv
